// ===== hw/rtl/json_string_unescape_assert.svh =====
// assertion macros used by the checker file of the string unescape block
// no dependencies; take in with `include by bare file name
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define JSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/jsu_pkg.sv =====
// shared types and constants for the json string unescape block
// no dependencies
`default_nettype none

package jsu_pkg;

   localparam int GROUP_BYTES = 3;

   // bytes produced by one input word, handed from front to back
   typedef struct packed {
      logic [GROUP_BYTES-1:0][7:0] bytes;
      logic [1:0]                  count;   // 1 to 3
      logic                        last;
   } group_type;

endpackage

`default_nettype wire

// ===== hw/rtl/jsu_queue.sv =====
// short queue of output groups between decode front and byte serializer
// depends on jsu_pkg
`default_nettype none

module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire jsu_pkg::group_type wr_data,
   output      logic               full,
   input  wire logic               rd_en,
   output      jsu_pkg::group_type rd_data,
   output      logic               rd_valid
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_front.sv =====
// decode front: tracks escape and \u state, turns each input word into a
// group of 0 to 3 output bytes; depends on jsu_pkg
`default_nettype none

module jsu_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   output      logic               grp_write,
   output      jsu_pkg::group_type grp_data
);
   import jsu_pkg::*;

   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CC_BS     = 8'h08;
   localparam logic [7:0] CC_FF     = 8'h0c;
   localparam logic [7:0] CC_LF     = 8'h0a;
   localparam logic [7:0] CC_CR     = 8'h0d;
   localparam logic [7:0] CC_TAB    = 8'h09;
   localparam logic [15:0] LIM_ONE  = 16'h0080;
   localparam logic [15:0] LIM_TWO  = 16'h0800;
   localparam logic [7:0] UTF_LEAD2 = 8'hc0;
   localparam logic [7:0] UTF_LEAD3 = 8'he0;
   localparam logic [7:0] UTF_CONT  = 8'h80;
   localparam logic [2:0] HEX_LEN   = 3'd4;

   logic        esc_ff, esc_in;
   logic        hex_ff, hex_in;
   logic [2:0]  seen_ff, seen_in;
   logic [15:0] code_ff, code_in;
   logic        ended_ff, ended_in;

   logic        is_hex;
   logic [3:0]  hex_val;

   always_comb begin
      is_hex  = 1'b0;
      hex_val = '0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         is_hex  = 1'b1;
         hex_val = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         is_hex  = 1'b1;
         hex_val = in_byte[3:0] + 4'd9;
      end
   end

   always_comb begin
      logic [1:0]                  n;
      logic [GROUP_BYTES-1:0][7:0] b;
      n        = '0;
      b        = '0;
      esc_in   = esc_ff;
      hex_in   = hex_ff;
      seen_in  = seen_ff;
      code_in  = code_ff;
      ended_in = ended_ff;

      if (hex_ff) begin
         if (seen_ff == '0 && !is_hex) begin
            // no digit after \u: literal backslash and u, byte taken as plain unless a backslash
            hex_in = 1'b0;
            b[n] = CH_BSLASH; n = n + 1'b1;
            b[n] = CH_U;      n = n + 1'b1;
            if (in_byte == CH_BSLASH) begin
               esc_in = 1'b1;
            end else begin
               b[n] = in_byte; n = n + 1'b1;
            end
         end else begin
            if (!ended_ff && is_hex) begin
               code_in = {code_ff[11:0], hex_val};
            end else begin
               ended_in = 1'b1;
            end
            seen_in = seen_ff + 1'b1;
            if (seen_in >= HEX_LEN || in_last) begin
               hex_in = 1'b0;
               if (code_in < LIM_ONE) begin
                  b[n] = code_in[7:0]; n = n + 1'b1;
               end else if (code_in < LIM_TWO) begin
                  b[n] = UTF_LEAD2 | {3'b000, code_in[10:6]}; n = n + 1'b1;
                  b[n] = UTF_CONT | {2'b00, code_in[5:0]};    n = n + 1'b1;
               end else begin
                  b[n] = UTF_LEAD3 | {4'b0000, code_in[15:12]}; n = n + 1'b1;
                  b[n] = UTF_CONT | {2'b00, code_in[11:6]};     n = n + 1'b1;
                  b[n] = UTF_CONT | {2'b00, code_in[5:0]};      n = n + 1'b1;
               end
            end
         end
      end else if (esc_ff) begin
         esc_in = 1'b0;
         case (in_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin
               b[n] = in_byte; n = n + 1'b1;
            end
            CH_B: begin
               b[n] = CC_BS; n = n + 1'b1;
            end
            CH_F: begin
               b[n] = CC_FF; n = n + 1'b1;
            end
            CH_N: begin
               b[n] = CC_LF; n = n + 1'b1;
            end
            CH_R: begin
               b[n] = CC_CR; n = n + 1'b1;
            end
            CH_T: begin
               b[n] = CC_TAB; n = n + 1'b1;
            end
            CH_U: begin
               hex_in   = 1'b1;
               seen_in  = '0;
               code_in  = '0;
               ended_in = 1'b0;
            end
            default: begin
               b[n] = CH_BSLASH; n = n + 1'b1;
               b[n] = in_byte;   n = n + 1'b1;
            end
         endcase
      end else if (in_byte == CH_BSLASH) begin
         esc_in = 1'b1;
      end else begin
         b[n] = in_byte; n = n + 1'b1;
      end

      // end of string flushes whatever is still held
      if (in_last) begin
         if (hex_in) begin
            b[n] = CH_BSLASH; n = n + 1'b1;
            b[n] = CH_U;      n = n + 1'b1;
         end else if (esc_in) begin
            b[n] = CH_BSLASH; n = n + 1'b1;
         end
      end

      grp_data.bytes = b;
      grp_data.count = n;
      grp_data.last  = in_last;
      grp_write      = accept && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= 1'b0;
         hex_ff   <= 1'b0;
         seen_ff  <= '0;
         code_ff  <= '0;
         ended_ff <= 1'b0;
      end else if (accept) begin
         if (in_last) begin
            esc_ff   <= 1'b0;
            hex_ff   <= 1'b0;
            seen_ff  <= '0;
            code_ff  <= '0;
            ended_ff <= 1'b0;
         end else begin
            esc_ff   <= esc_in;
            hex_ff   <= hex_in;
            seen_ff  <= seen_in;
            code_ff  <= code_in;
            ended_ff <= ended_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_back.sv =====
// byte serializer: walks the head group one byte per cycle into the
// result register while it is empty or popped; depends on jsu_pkg
`default_nettype none

module jsu_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               grp_valid,
   input  wire jsu_pkg::group_type grp_head,
   output      logic               grp_done,
   output      logic [7:0]         out_byte,
   output      logic               out_last,
   output      logic               out_empty,
   input  wire logic               out_pop
);
   import jsu_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       load, final_byte;

   assign load       = (!valid_ff || out_pop) && grp_valid;
   assign final_byte = ((idx_ff + 1'b1) == grp_head.count);
   assign grp_done   = load && final_byte;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_pop;
      if (load) begin
         idx_in   = final_byte ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= grp_head.bytes[idx_ff];
         last_ff <= grp_head.last && final_byte;
      end
   end

   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_empty = !valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/json_string_unescape.sv =====
// Streaming JSON string unescaper.
// Input queue side: one raw content byte per word (req_in_byte) with
// req_in_last on the final byte of the string; a word is taken at a clock
// edge with push high and full low.
// Result queue side: unescaped UTF-8 bytes on rsp_out_byte with rsp_out_last
// on the final byte of the string; the word shown while empty is low is taken
// at an edge with pop high.
// A word that yields bytes is written into the group queue, and its first
// byte then moves into the result register. Throughput: one input word per
// cycle while words yield at most one byte each and pop keeps up; the result
// side delivers one byte per cycle while popped, so a word that yields two or
// three bytes (unknown escapes, \u values of 0x80 and up) holds the serializer
// until each of its bytes is out. The group queue between decoder and
// serializer (QUEUE_DEPTH groups) absorbs these bursts; full rises only when
// it fills. A stalled result side holds the result word steady and backs up
// into the group queue, then into full. Reset clears the escape state, the
// queue and the result register; words held at that time are dropped.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
`default_nettype none

module json_string_unescape #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output      logic       full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output      logic       empty,
   input  wire logic       pop,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_out_last
);
   import jsu_pkg::*;

   logic      accept;
   logic      grp_write, grp_valid, grp_done;
   group_type grp_wr, grp_head;

   assign accept = push && !full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .grp_write (grp_write),
      .grp_data  (grp_wr)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (grp_write),
      .wr_data  (grp_wr),
      .full     (full),
      .rd_en    (grp_done),
      .rd_data  (grp_head),
      .rd_valid (grp_valid)
   );

   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_valid (grp_valid),
      .grp_head  (grp_head),
      .grp_done  (grp_done),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_out_last),
      .out_empty (empty),
      .out_pop   (pop)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_checker.sv =====
// port-level checks for json_string_unescape, bound to the top level
// depends on json_string_unescape_assert.svh
`default_nettype none

`include "json_string_unescape_assert.svh"

module jsu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       push,
   input wire logic       full,
   input wire logic       empty,
   input wire logic       pop,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last
);

   logic took;
   assign took = push && !full;

   `JSU_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, empty && !full,
                    "reset left words behind")
   `JSU_ASSERT_NEXT(a_stall_holds, clock, reset, !empty && !pop,
                    !empty && $stable(rsp_out_byte) && $stable(rsp_out_last),
                    "stalled result word changed")
   `JSU_ASSERT_NOW(a_full_has_word, clock, reset, full, !empty,
                   "queue full while result register idle")
   `JSU_ASSERT_NEXT(a_no_phantom, clock, reset, empty && !took && !$past(took), empty,
                    "result word with no input word behind it")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
   .clock        (clock),
   .reset        (reset),
   .push         (push),
   .full         (full),
   .empty        (empty),
   .pop          (pop),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);

`default_nettype wire
